/* sv/irct_pkg.sv */
// Shared types, constants and register map for the IR command frame transmitter.
package irct_pkg;

  localparam int FRAME_LENGTH = 19;
  localparam int FRAME_W      = 19;
  localparam int POS_W        = 5;
  localparam int IVL_W        = 20;
  localparam int CAR_W        = 10;
  localparam int BIT_W        = 16;
  localparam int STEP_W       = 3;
  localparam int BLINK_HALVES = 6;

  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;
  localparam int REG_IDX_W = 3;

  // Register indexes (byte address is 4 * index)
  localparam logic [REG_IDX_W-1:0] REG_CARRIER_TOP = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_BIT_TICKS   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_BLINK_TICKS = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_HOLD_TICKS  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_RESET_FRAME = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_READY_FRAME = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_GO_FRAME    = 3'd6;

  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_RESET = 2'd1,
    CMD_READY = 2'd2,
    CMD_GO    = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [CAR_W-1:0]   carrier_top;
    logic [BIT_W-1:0]   bit_ticks;
    logic [IVL_W-1:0]   blink_ticks;
    logic [IVL_W-1:0]   hold_ticks;
    logic [FRAME_W-1:0] reset_frame;
    logic [FRAME_W-1:0] ready_frame;
    logic [FRAME_W-1:0] go_frame;
  } cfg_t;

  typedef struct packed {
    logic reset_pressed;
    logic ready_pressed;
    logic go_pressed;
  } btn_t;

  typedef struct packed {
    logic       ir_out;
    logic       status_enable;
    logic       status_level;
    logic       busy_res;
    logic [1:0] active_command;
  } drv_t;

endpackage

/* sv/irct_regs.sv */
// APB-style configuration register block.
module irct_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [irct_pkg::PADDR_W-1:0]  paddr,
  input  logic [irct_pkg::PDATA_W-1:0]  pwdata,
  output logic [irct_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  output irct_pkg::cfg_t                cfg
);

  logic [irct_pkg::REG_IDX_W-1:0] idx;
  logic                           wr;

  assign idx    = paddr[irct_pkg::PADDR_W-1:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.carrier_top <= irct_pkg::CAR_W'(104);
      cfg.bit_ticks   <= irct_pkg::BIT_W'(3200);
      cfg.blink_ticks <= irct_pkg::IVL_W'(64000);
      cfg.hold_ticks  <= irct_pkg::IVL_W'(512000);
      cfg.reset_frame <= irct_pkg::FRAME_W'(66202);
      cfg.ready_frame <= irct_pkg::FRAME_W'(66200);
      cfg.go_frame    <= irct_pkg::FRAME_W'(66216);
    end else if (wr) begin
      unique case (idx)
        irct_pkg::REG_CARRIER_TOP: cfg.carrier_top <= pwdata[irct_pkg::CAR_W-1:0];
        irct_pkg::REG_BIT_TICKS:   cfg.bit_ticks   <= pwdata[irct_pkg::BIT_W-1:0];
        irct_pkg::REG_BLINK_TICKS: cfg.blink_ticks <= pwdata[irct_pkg::IVL_W-1:0];
        irct_pkg::REG_HOLD_TICKS:  cfg.hold_ticks  <= pwdata[irct_pkg::IVL_W-1:0];
        irct_pkg::REG_RESET_FRAME: cfg.reset_frame <= pwdata[irct_pkg::FRAME_W-1:0];
        irct_pkg::REG_READY_FRAME: cfg.ready_frame <= pwdata[irct_pkg::FRAME_W-1:0];
        irct_pkg::REG_GO_FRAME:    cfg.go_frame    <= pwdata[irct_pkg::FRAME_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      irct_pkg::REG_CARRIER_TOP: prdata = irct_pkg::PDATA_W'(cfg.carrier_top);
      irct_pkg::REG_BIT_TICKS:   prdata = irct_pkg::PDATA_W'(cfg.bit_ticks);
      irct_pkg::REG_BLINK_TICKS: prdata = irct_pkg::PDATA_W'(cfg.blink_ticks);
      irct_pkg::REG_HOLD_TICKS:  prdata = irct_pkg::PDATA_W'(cfg.hold_ticks);
      irct_pkg::REG_RESET_FRAME: prdata = irct_pkg::PDATA_W'(cfg.reset_frame);
      irct_pkg::REG_READY_FRAME: prdata = irct_pkg::PDATA_W'(cfg.ready_frame);
      irct_pkg::REG_GO_FRAME:    prdata = irct_pkg::PDATA_W'(cfg.go_frame);
      default:                   prdata = '0;
    endcase
  end

endmodule

/* sv/irct_carrier.sv */
// Free-running square carrier, advanced once per accepted tick.
module irct_carrier (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        tick,
  input  logic [irct_pkg::CAR_W-1:0]  carrier_top,
  output logic                        carrier
);

  logic [irct_pkg::CAR_W-1:0] count;
  logic                       phase;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      phase <= 1'b0;
    end else if (tick) begin
      if (count >= carrier_top) begin
        count <= '0;
        phase <= ~phase;
      end else begin
        count <= count + 1'b1;
      end
    end
  end

  // phase as it stood before this tick's update
  assign carrier = phase;

endmodule

/* sv/irct_seq.sv */
// Command sequencer: frame bit timing, status pin pattern and result fields.
module irct_seq (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 tick,
  input  irct_pkg::btn_t       btn,
  input  irct_pkg::cfg_t       cfg,
  input  logic                 carrier,
  output irct_pkg::drv_t       res
);

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_FRAME  = 2'd1,
    PH_STATUS = 2'd2
  } phase_t;

  phase_t                              phase, phase_next;
  irct_pkg::cmd_t                      cmd, cmd_next;
  logic [irct_pkg::FRAME_W-1:0]        frame_bits, frame_bits_next;
  logic [irct_pkg::POS_W-1:0]          pos, pos_next, pos_inc;
  logic [irct_pkg::IVL_W-1:0]          ivl, ivl_next, ivl_inc, lim;
  logic                                ivl_done;
  logic [irct_pkg::STEP_W-1:0]         step, step_next, step_inc;
  logic                                status_latch, status_latch_next;
  logic [(1 << irct_pkg::POS_W)-1:0]   frame_ext;

  always_comb begin
    phase_next        = phase;
    cmd_next          = cmd;
    frame_bits_next   = frame_bits;
    pos_next          = pos;
    ivl_next          = ivl;
    step_next         = step;
    status_latch_next = status_latch;
    res               = '0;
    res.status_level  = status_latch;

    // pick a new command when idle; the same tick already sends bit 0
    if (phase != PH_FRAME && phase != PH_STATUS) begin
      phase_next = PH_IDLE;
      if (btn.reset_pressed) begin
        cmd_next        = irct_pkg::CMD_RESET;
        frame_bits_next = cfg.reset_frame;
      end else if (btn.ready_pressed) begin
        cmd_next        = irct_pkg::CMD_READY;
        frame_bits_next = cfg.ready_frame;
      end else if (btn.go_pressed) begin
        cmd_next        = irct_pkg::CMD_GO;
        frame_bits_next = cfg.go_frame;
      end else begin
        cmd_next = irct_pkg::CMD_NONE;
      end
      if (cmd_next != irct_pkg::CMD_NONE) begin
        phase_next = PH_FRAME;
        pos_next   = '0;
        ivl_next   = '0;
        step_next  = '0;
      end
    end

    // one shared interval timer; limit depends on what is running
    if (phase_next == PH_FRAME) begin
      lim = irct_pkg::IVL_W'(cfg.bit_ticks);
    end else if (cmd_next == irct_pkg::CMD_RESET) begin
      lim = cfg.blink_ticks;
    end else begin
      lim = cfg.hold_ticks;
    end
    ivl_inc   = ivl_next + 1'b1;
    ivl_done  = (ivl_inc >= lim) || (ivl_inc == '0);
    pos_inc   = pos_next + 1'b1;
    step_inc  = step_next + 1'b1;
    frame_ext = (1 << irct_pkg::POS_W)'(frame_bits_next);

    unique case (phase_next)
      PH_FRAME: begin
        res.ir_out         = ~frame_ext[pos_next] & carrier;
        res.status_enable  = 1'b1;
        res.busy_res       = 1'b1;
        res.active_command = cmd_next;
        ivl_next           = ivl_done ? '0 : ivl_inc;
        if (ivl_done) begin
          if (32'(pos_inc) >= irct_pkg::FRAME_LENGTH || pos_inc == '0) begin
            phase_next        = PH_STATUS;
            step_next         = '0;
            pos_next          = '0;
            status_latch_next = (cmd_next == irct_pkg::CMD_READY);
          end else begin
            pos_next = pos_inc;
          end
        end
      end
      PH_STATUS: begin
        res.status_enable  = 1'b1;
        res.busy_res       = 1'b1;
        res.active_command = cmd_next;
        ivl_next           = ivl_done ? '0 : ivl_inc;
        if (ivl_done) begin
          if (cmd_next == irct_pkg::CMD_RESET) begin
            if (32'(step_inc) >= irct_pkg::BLINK_HALVES) begin
              phase_next = PH_IDLE;
              step_next  = '0;
            end else begin
              step_next         = step_inc;
              status_latch_next = ~status_latch;
            end
          end else begin
            phase_next = PH_IDLE;
          end
        end
        if (phase_next == PH_IDLE) cmd_next = irct_pkg::CMD_NONE;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      cmd          <= irct_pkg::CMD_NONE;
      frame_bits   <= '0;
      pos          <= '0;
      ivl          <= '0;
      step         <= '0;
      status_latch <= 1'b0;
    end else if (tick) begin
      phase        <= phase_next;
      cmd          <= cmd_next;
      frame_bits   <= frame_bits_next;
      pos          <= pos_next;
      ivl          <= ivl_next;
      step         <= step_next;
      status_latch <= status_latch_next;
    end
  end

endmodule

/* sv/ir_command_frame_transmitter_unit.sv */
// Top level of the IR command frame transmitter.
//
// Usage:
//  - btn channel (btn_valid/btn_ready/btn): one transfer per base-clock tick,
//    carrying the three button flags. Each accepted transfer advances the
//    carrier counter, bit timer and status timer by exactly one tick.
//  - drv channel (drv_valid/drv_ready/drv): one result transfer per accepted
//    tick, in order: gated carrier, status pin enable/level, busy flag and
//    the active command code.
//  - APB-style port: seven 32-bit registers at 4*index, pready tied high.
//    Write only while no tick is outstanding.
// Timing: a result appears on drv in the cycle after its tick is accepted.
// Throughput: one tick per cycle unless drv stalls; all per-tick work is one
//   pass of logic from the state registers to the result register, the widest
//   piece being the shared 20-bit interval increment and compare.
// Reset (rst, synchronous): registers return to defaults, carrier and
//   sequencer clear to idle, the result register empties.
// Stall: while drv is stalled the held result stays put; btn_ready drops
//   only when the result register is full and not being taken.
module ir_command_frame_transmitter_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          btn_valid,
  output logic                          btn_ready,
  input  irct_pkg::btn_t                btn,
  output logic                          drv_valid,
  input  logic                          drv_ready,
  output irct_pkg::drv_t                drv,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [irct_pkg::PADDR_W-1:0]  paddr,
  input  logic [irct_pkg::PDATA_W-1:0]  pwdata,
  output logic [irct_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  irct_pkg::cfg_t cfg;
  irct_pkg::drv_t res;
  logic           tick;
  logic           carrier;

  // accept whenever the result slot is free or emptying this cycle
  assign btn_ready = !drv_valid || drv_ready;
  assign tick      = btn_valid && btn_ready;

  irct_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  irct_carrier u_carrier (
    .clk         (clk),
    .rst         (rst),
    .tick        (tick),
    .carrier_top (cfg.carrier_top),
    .carrier     (carrier)
  );

  irct_seq u_seq (
    .clk     (clk),
    .rst     (rst),
    .tick    (tick),
    .btn     (btn),
    .cfg     (cfg),
    .carrier (carrier),
    .res     (res)
  );

  // result register: payload needs no reset
  always_ff @(posedge clk) begin
    if (rst) begin
      drv_valid <= 1'b0;
    end else if (tick) begin
      drv_valid <= 1'b1;
    end else if (drv_ready) begin
      drv_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick) begin
      drv <= res;
    end
  end

endmodule

/* sv/irct_checker.sv */
// Port-level checker for the IR command frame transmitter, with its bind.
module irct_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          btn_ready,
  input logic                          drv_valid,
  input logic                          drv_ready,
  input irct_pkg::drv_t                drv,
  input logic                          psel,
  input logic                          penable,
  input logic                          pwrite,
  input logic [irct_pkg::PADDR_W-1:0]  paddr,
  input logic [irct_pkg::PDATA_W-1:0]  pwdata,
  input logic [irct_pkg::PDATA_W-1:0]  prdata,
  input logic                          pready
);

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk) rst |=> !drv_valid)
    else $error("result pending after reset");

  // an empty result slot never blocks the input side
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !drv_valid |-> btn_ready)
    else $error("input stalled with empty result register");

  // a stalled result holds
  a_drv_hold: assert property (@(posedge clk) disable iff (rst)
    drv_valid && !drv_ready |=> drv_valid && $stable(drv))
    else $error("stalled result changed");

  // idle results carry no drive and no command
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    drv_valid && !drv.busy_res |->
      !drv.ir_out && !drv.status_enable && drv.active_command == irct_pkg::CMD_NONE)
    else $error("idle result shows activity");

  // carrier_top write reads back
  a_cfg_readback: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && pready &&
    paddr[irct_pkg::PADDR_W-1:2] == irct_pkg::REG_CARRIER_TOP |=>
      paddr[irct_pkg::PADDR_W-1:2] != irct_pkg::REG_CARRIER_TOP ||
      prdata[irct_pkg::CAR_W-1:0] == $past(pwdata[irct_pkg::CAR_W-1:0]))
    else $error("carrier_top read-back mismatch");

endmodule

bind ir_command_frame_transmitter_unit irct_checker u_irct_checker (.*);

/* test/irct_drive_checker.sv */
// Checker for the IR transmitter: predicts each drive result from the accepted ticks and compares.
module irct_drive_checker
  import irct_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               btn_valid,
  input  logic               btn_ready,
  input  btn_t               btn,
  input  logic               drv_valid,
  input  logic               drv_ready,
  input  drv_t               drv,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output int                 mismatch_count,
  output int                 results_outstanding,
  output logic               sequencer_idle
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {
    SEQ_IDLE   = 2'd0,
    SEQ_FRAME  = 2'd1,
    SEQ_STATUS = 2'd2
  } seq_t;

  // own copy of the register file and sequencer state
  cfg_t               cfg;
  logic [CAR_W-1:0]   carrier_count;
  logic               carrier_phase;
  seq_t               seq;
  cmd_t               cmd;
  logic [FRAME_W-1:0] frame_bits;
  logic [POS_W-1:0]   bit_pos;
  logic [IVL_W-1:0]   interval_count;
  logic [STEP_W-1:0]  blink_step;
  logic               status_latch;

  drv_t expected_drive_q[$];
  int   result_index;

  // shared interval timer; a span of zero ends on every tick
  function automatic logic interval_done(input logic [IVL_W-1:0] span);
    logic [IVL_W-1:0] nxt;
    nxt = interval_count + 1'b1;
    if (nxt >= span || nxt == '0) begin
      interval_count = '0;
      return 1'b1;
    end
    interval_count = nxt;
    return 1'b0;
  endfunction

  function automatic drv_t predict_drive(input btn_t b);
    drv_t d;
    logic carrier;
    carrier = carrier_phase;
    d = '0;
    if (seq != SEQ_FRAME && seq != SEQ_STATUS) begin
      seq = SEQ_IDLE;
      if (b.reset_pressed) begin
        cmd        = CMD_RESET;
        frame_bits = cfg.reset_frame;
      end else if (b.ready_pressed) begin
        cmd        = CMD_READY;
        frame_bits = cfg.ready_frame;
      end else if (b.go_pressed) begin
        cmd        = CMD_GO;
        frame_bits = cfg.go_frame;
      end else begin
        cmd = CMD_NONE;
      end
      if (cmd != CMD_NONE) begin
        seq            = SEQ_FRAME;
        bit_pos        = '0;
        interval_count = '0;
        blink_step     = '0;
      end
    end

    d.status_level = status_latch;

    if (seq == SEQ_FRAME) begin
      d.ir_out         = ((bit_pos < FRAME_W) ? frame_bits[bit_pos] : 1'b0) ? 1'b0 : carrier;
      d.status_enable  = 1'b1;
      d.busy_res       = 1'b1;
      d.active_command = cmd;
      if (interval_done(IVL_W'(cfg.bit_ticks))) begin
        bit_pos = bit_pos + 1'b1;
        if (bit_pos >= FRAME_LENGTH || bit_pos == '0) begin
          seq          = SEQ_STATUS;
          blink_step   = '0;
          bit_pos      = '0;
          status_latch = (cmd == CMD_READY);
        end
      end
    end else if (seq == SEQ_STATUS) begin
      d.status_enable  = 1'b1;
      d.busy_res       = 1'b1;
      d.active_command = cmd;
      if (cmd == CMD_RESET) begin
        if (interval_done(cfg.blink_ticks)) begin
          blink_step = blink_step + 1'b1;
          if (blink_step >= BLINK_HALVES) begin
            seq        = SEQ_IDLE;
            blink_step = '0;
          end else begin
            status_latch = ~status_latch;
          end
        end
      end else if (interval_done(cfg.hold_ticks)) begin
        seq = SEQ_IDLE;
      end
      if (seq == SEQ_IDLE) cmd = CMD_NONE;
    end

    if (carrier_count >= cfg.carrier_top) begin
      carrier_count = '0;
      carrier_phase = ~carrier_phase;
    end else begin
      carrier_count = carrier_count + 1'b1;
    end
    return d;
  endfunction

  always @(posedge clk) begin : watch
    drv_t want;
    if (rst) begin
      cfg.carrier_top     = CAR_W'(104);
      cfg.bit_ticks       = BIT_W'(3200);
      cfg.blink_ticks     = IVL_W'(64000);
      cfg.hold_ticks      = IVL_W'(512000);
      cfg.reset_frame     = FRAME_W'(66202);
      cfg.ready_frame     = FRAME_W'(66200);
      cfg.go_frame        = FRAME_W'(66216);
      carrier_count       = '0;
      carrier_phase       = 1'b0;
      seq                 = SEQ_IDLE;
      cmd                 = CMD_NONE;
      frame_bits          = '0;
      bit_pos             = '0;
      interval_count      = '0;
      blink_step          = '0;
      status_latch        = 1'b0;
      expected_drive_q.delete();
      result_index        = 0;
      mismatch_count      = 0;
      results_outstanding = 0;
      sequencer_idle     <= 1'b1;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[PADDR_W-1:2])
          REG_CARRIER_TOP: cfg.carrier_top = pwdata[CAR_W-1:0];
          REG_BIT_TICKS:   cfg.bit_ticks   = pwdata[BIT_W-1:0];
          REG_BLINK_TICKS: cfg.blink_ticks = pwdata[IVL_W-1:0];
          REG_HOLD_TICKS:  cfg.hold_ticks  = pwdata[IVL_W-1:0];
          REG_RESET_FRAME: cfg.reset_frame = pwdata[FRAME_W-1:0];
          REG_READY_FRAME: cfg.ready_frame = pwdata[FRAME_W-1:0];
          REG_GO_FRAME:    cfg.go_frame    = pwdata[FRAME_W-1:0];
          default: ;
        endcase
      end

      if (btn_valid && btn_ready) begin
        expected_drive_q.push_back(predict_drive(btn));
        sequencer_idle <= (seq == SEQ_IDLE);
      end

      if (drv_valid && drv_ready) begin
        if (expected_drive_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("drive result %0d arrived with nothing expected: %b", result_index, drv);
        end else begin
          want = expected_drive_q.pop_front();
          if (drv.ir_out !== want.ir_out || drv.status_enable !== want.status_enable ||
              drv.status_level !== want.status_level || drv.busy_res !== want.busy_res ||
              drv.active_command !== want.active_command) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $write("drive result %0d differs: exp ir=%b en=%b lvl=%b busy=%b cmd=%0d",
                     result_index, want.ir_out, want.status_enable, want.status_level,
                     want.busy_res, want.active_command);
              $display(" / got ir=%b en=%b lvl=%b busy=%b cmd=%0d", drv.ir_out,
                       drv.status_enable, drv.status_level, drv.busy_res,
                       drv.active_command);
            end
          end
        end
        result_index++;
      end
      results_outstanding = expected_drive_q.size();
    end
  end

endmodule

/* test/tb_ir_command_frame_transmitter_unit.sv */
// Top of the IR transmitter testbench: clock, reset, stimulus and verdict.
module tb_ir_command_frame_transmitter_unit import irct_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TICK_TARGET  = 1650;    // rough size of the whole run in ticks
  localparam int CYCLE_LIMIT  = 200000;  // many times the slowest legal run
  localparam int DRAIN_CYCLES = 8;       // the result is registered; plenty

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               btn_valid = 1'b0;
  logic               btn_ready;
  btn_t               btn = '0;
  logic               drv_valid;
  logic               drv_ready = 1'b0;
  drv_t               drv;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  int   mismatch_count;
  int   results_outstanding;
  logic sequencer_idle;

  // idling percentages, moved through three regimes as the run progresses
  int send_gap_pct   = 35;
  int recv_stall_pct = 74;
  int ticks_sent     = 0;
  int cycle_count    = 0;

  ir_command_frame_transmitter_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .btn_valid(btn_valid),
    .btn_ready(btn_ready),
    .btn      (btn),
    .drv_valid(drv_valid),
    .drv_ready(drv_ready),
    .drv      (drv),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  irct_drive_checker i_checker (
    .clk                (clk),
    .rst                (rst),
    .btn_valid          (btn_valid),
    .btn_ready          (btn_ready),
    .btn                (btn),
    .drv_valid          (drv_valid),
    .drv_ready          (drv_ready),
    .drv                (drv),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .pready             (pready),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .mismatch_count     (mismatch_count),
    .results_outstanding(results_outstanding),
    .sequencer_idle     (sequencer_idle)
  );

  always #5 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // receiver back-pressure, redrawn every cycle on the falling edge
  always @(negedge clk) begin
    drv_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // One button transfer. Gaps are taken before the transfer; after acceptance
  // nothing is driven here, so the next falling edge belongs to whoever runs
  // next (new payload, gap, or drain) - valid is never touched twice an edge.
  task automatic push_tick(input btn_t b);
    if (ticks_sent < 550) begin
      send_gap_pct   = 35;
      recv_stall_pct = 74;
    end else if (ticks_sent < 1100) begin
      send_gap_pct   = 74;
      recv_stall_pct = 35;
    end else begin
      send_gap_pct   = 0;
      recv_stall_pct = 0;
    end
    while ($urandom_range(99) < send_gap_pct) begin
      @(negedge clk);
      btn_valid <= 1'b0;
    end
    @(negedge clk);
    btn_valid <= 1'b1;
    btn       <= b;
    do @(posedge clk); while (!btn_ready);
    ticks_sent++;
  endtask

  // hold off the sender until every predicted result has been taken
  task automatic wait_results_drained();
    @(negedge clk);
    btn_valid <= 1'b0;
    while (results_outstanding != 0) @(negedge clk);
  endtask

  // APB write: setup cycle, then access cycle until pready
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [PDATA_W-1:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Frame registers get junk above bit 18 so the width masking is exercised.
  task automatic load_config(input cfg_t c);
    write_reg(REG_CARRIER_TOP, PDATA_W'(c.carrier_top));
    write_reg(REG_BIT_TICKS,   PDATA_W'(c.bit_ticks));
    write_reg(REG_BLINK_TICKS, PDATA_W'(c.blink_ticks));
    write_reg(REG_HOLD_TICKS,  PDATA_W'(c.hold_ticks));
    write_reg(REG_RESET_FRAME, {(PDATA_W-FRAME_W)'($urandom()), c.reset_frame});
    write_reg(REG_READY_FRAME, {(PDATA_W-FRAME_W)'($urandom()), c.ready_frame});
    write_reg(REG_GO_FRAME,    {(PDATA_W-FRAME_W)'($urandom()), c.go_frame});
  endtask

  // Short timers so a command completes in tens of ticks; carrier top swings
  // between zero, full scale and a handful of small values.
  function automatic cfg_t random_config();
    cfg_t c;
    case ($urandom_range(3))
      0:       c.carrier_top = '0;
      1:       c.carrier_top = '1;
      default: c.carrier_top = CAR_W'($urandom_range(1, 6));
    endcase
    c.bit_ticks   = BIT_W'($urandom_range(0, 3));
    c.blink_ticks = IVL_W'($urandom_range(0, 8));
    c.hold_ticks  = IVL_W'($urandom_range(0, 30));
    c.reset_frame = FRAME_W'($urandom());
    c.ready_frame = FRAME_W'($urandom());
    c.go_frame    = FRAME_W'($urandom());
    return c;
  endfunction

  // presses are frequent enough that the sequencer rarely sits idle for long
  function automatic btn_t random_buttons();
    btn_t b;
    b.reset_pressed = ($urandom_range(4) == 0);
    b.ready_pressed = ($urandom_range(3) == 0);
    b.go_pressed    = ($urandom_range(2) == 0);
    return b;
  endfunction

  initial begin : stimulus
    cfg_t c;
    btn_t presses [6];
    int   n;
    int   phase;

    // packed order is {reset, ready, go}
    presses[0] = btn_t'(3'b111);  // all three: reset has priority
    presses[1] = btn_t'(3'b011);  // ready beats go
    presses[2] = btn_t'(3'b001);  // go alone
    presses[3] = btn_t'(3'b110);
    presses[4] = btn_t'(3'b101);
    presses[5] = btn_t'(3'b010);  // ready alone: status held high afterwards

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset defaults: a go command with the stock timing, long enough to see
    // the carrier toggle while the first frame bit, a gated 0, is sent.
    push_tick(btn_t'(3'b001));
    repeat (149) push_tick(random_buttons());

    // Zero timers (each treated as one tick), frames at both extremes. The go
    // command above carries on under these settings.
    wait_results_drained();
    c             = '0;
    c.ready_frame = '1;
    c.go_frame    = FRAME_W'(19'h2AAAA);
    load_config(c);

    // Directed priority cases. sequencer_idle lags by one transfer, so the
    // second press (ignored while busy) also guarantees a busy reading.
    for (int i = 0; i < 6; i++) begin
      while (!sequencer_idle) push_tick('0);
      push_tick(presses[i]);
      push_tick(presses[i]);
    end

    // Random phases, each with fresh register values; one phase puts every
    // register at full scale and the next one cuts that command short.
    phase = 0;
    while (ticks_sent < TICK_TARGET) begin
      if (phase == 2) begin
        c = '1;
        n = 60;
      end else begin
        c = random_config();
        n = $urandom_range(100, 160);
      end
      wait_results_drained();
      load_config(c);
      for (int i = 0; i < n; i++) begin
        if (phase == 4 && i == n / 2) wait_results_drained();
        push_tick(random_buttons());
      end
      phase++;
    end

    wait_results_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && results_outstanding == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/irct_pkg.sv
sv/irct_regs.sv
sv/irct_carrier.sv
sv/irct_seq.sv
sv/ir_command_frame_transmitter_unit.sv
sv/irct_checker.sv
test/irct_drive_checker.sv
test/tb_ir_command_frame_transmitter_unit.sv
